// File: sv/qdpr_pkg.sv
// ---------------------------------------------------------------------------
// qdpr_pkg: shared types and constants for the quantized dot product block
// Payload structs for the request and response channels, the register file
// contents, register indexes and the controller/datapath command bundle.
// ---------------------------------------------------------------------------
package qdpr_pkg;

   // Request payload: one activation/weight pair of a row.
   typedef struct packed {
      logic [7:0]         activation;
      logic [7:0]         weight;
      logic signed [31:0] bias;
      logic               last;
   } req_type;

   // Response payload: one requantized row result.
   typedef struct packed {
      logic signed [32:0] out_value;
      logic               overflow;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic              signed_mode;
      logic [7:0]        input_zero_point;
      logic [7:0]        weight_zero_point;
      logic [7:0]        output_zero_point;
      logic [31:0]       scale_mult;
      logic signed [6:0] scale_shift;
      logic [5:0]        out_bits;
   } cfg_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_SIGNED_MODE       = 3'd0;
   localparam logic [2:0] REG_INPUT_ZERO_POINT  = 3'd1;
   localparam logic [2:0] REG_WEIGHT_ZERO_POINT = 3'd2;
   localparam logic [2:0] REG_OUTPUT_ZERO_POINT = 3'd3;
   localparam logic [2:0] REG_SCALE_MULT        = 3'd4;
   localparam logic [2:0] REG_SCALE_SHIFT       = 3'd5;
   localparam logic [2:0] REG_OUT_BITS          = 3'd6;

   // Register reset values.
   localparam logic [31:0] SCALE_MULT_RESET = 32'd1;
   localparam logic [5:0]  OUT_BITS_RESET   = 6'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accum;      // accumulate the product of the accepted pair
      logic bias_add;   // add the captured bias into the accumulator
      logic multiply;   // multiply the accumulator by scale_mult
      logic shift;      // rounding shift of the product
      logic load_out;   // saturate into the response register, clear the row
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;       // the pair on the request channel ends a row
   } status_type;

endpackage

// File: sv/qdpr_csr.sv
// ---------------------------------------------------------------------------
// qdpr_csr: configuration register file
// Holds the seven requantization settings. Writes are taken in every cycle;
// an index past the last register is ignored.
// ---------------------------------------------------------------------------
module qdpr_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output qdpr_pkg::cfg_type  cfg
);

   qdpr_pkg::cfg_type cfg_ff;
   qdpr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode a write transfer into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            qdpr_pkg::REG_SIGNED_MODE:       cfg_in.signed_mode       = csr_data[0];
            qdpr_pkg::REG_INPUT_ZERO_POINT:  cfg_in.input_zero_point  = csr_data[7:0];
            qdpr_pkg::REG_WEIGHT_ZERO_POINT: cfg_in.weight_zero_point = csr_data[7:0];
            qdpr_pkg::REG_OUTPUT_ZERO_POINT: cfg_in.output_zero_point = csr_data[7:0];
            qdpr_pkg::REG_SCALE_MULT:        cfg_in.scale_mult        = csr_data;
            qdpr_pkg::REG_SCALE_SHIFT:       cfg_in.scale_shift       = $signed(csr_data[6:0]);
            qdpr_pkg::REG_OUT_BITS:          cfg_in.out_bits          = csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                   <= '0;
         cfg_ff.scale_mult        <= qdpr_pkg::SCALE_MULT_RESET;
         cfg_ff.out_bits          <= qdpr_pkg::OUT_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/qdpr_ctrl.sv
// ---------------------------------------------------------------------------
// qdpr_ctrl: row sequencer
// Accepts pairs while accumulating, then steps the datapath through bias
// add, multiply, shift and saturation, and owns the response valid flag.
// ---------------------------------------------------------------------------
module qdpr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  qdpr_pkg::status_type  status,
   output qdpr_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_BIAS,
      ST_MUL,
      ST_SHIFT,
      ST_SAT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_xfer;
   logic      out_free;

   assign req_stall = (state_ff != ST_ACCUM);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   // The response register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Commands follow the state directly.
   always_comb begin
      cmd          = '0;
      cmd.accum    = req_xfer;
      cmd.bias_add = (state_ff == ST_BIAS);
      cmd.multiply = (state_ff == ST_MUL);
      cmd.shift    = (state_ff == ST_SHIFT);
      cmd.load_out = (state_ff == ST_SAT) && out_free;
   end

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_xfer && status.last) state_in = ST_BIAS;
         end
         ST_BIAS:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_SAT;
         ST_SAT: begin
            if (out_free) begin
               state_in     = ST_ACCUM;
               rsp_valid_in = 1'b1;
            end
         end
         default:  state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/qdpr_datapath.sv
// ---------------------------------------------------------------------------
// qdpr_datapath: MAC, requantization stages and response register
// One 9x9 multiply-accumulate per accepted pair, then bias add, a 32x33
// scale multiply, a rounding shift and zero point plus saturation.
// ---------------------------------------------------------------------------
module qdpr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  qdpr_pkg::cfg_type     cfg,
   input  qdpr_pkg::req_type     req_data,
   output qdpr_pkg::rsp_type     rsp_data,
   input  qdpr_pkg::cmd_type     cmd,
   output qdpr_pkg::status_type  status
);

   // Shifted values are clamped to this magnitude; it lies beyond every output range.
   localparam logic signed [37:0] CLAMP_HI = 38'sd68719476736;
   localparam logic signed [37:0] CLAMP_LO = -38'sd68719476736;

   logic signed [31:0] acc_ff,   acc_in;
   logic               ovf_ff,   ovf_in;
   logic signed [31:0] bias_ff;
   logic signed [63:0] prod_ff;
   logic signed [37:0] shift_ff;
   qdpr_pkg::rsp_type  rsp_ff;

   logic signed [8:0]  act_s, wgt_s;
   logic signed [17:0] pair_prod;
   logic signed [31:0] addend, acc_sum;
   logic signed [64:0] mul_full;
   logic [5:0]         rsh_amt, half_idx;
   logic signed [63:0] rsh_val;
   logic [6:0]         lsh_amt;
   logic signed [37:0] prod_cl;
   logic signed [71:0] lsh_wide;
   logic signed [37:0] shift_in;
   logic [5:0]         sat_bits;
   logic signed [38:0] sat_val, sat_hi, sat_lo, sat_res;

   function automatic logic signed [37:0] clamp64(input logic signed [63:0] v);
      if (v > 64'(CLAMP_HI))      clamp64 = CLAMP_HI;
      else if (v < 64'(CLAMP_LO)) clamp64 = CLAMP_LO;
      else                        clamp64 = v[37:0];
   endfunction

   function automatic logic signed [37:0] clamp72(input logic signed [71:0] v);
      if (v > 72'(CLAMP_HI))      clamp72 = CLAMP_HI;
      else if (v < 72'(CLAMP_LO)) clamp72 = CLAMP_LO;
      else                        clamp72 = v[37:0];
   endfunction

   assign status.last = req_data.last;
   assign rsp_data    = rsp_ff;

   // Operand decode and pair product.
   always_comb begin
      if (cfg.signed_mode) begin
         act_s = $signed({req_data.activation[7], req_data.activation});
         wgt_s = $signed({req_data.weight[7], req_data.weight});
      end else begin
         act_s = $signed({1'b0, req_data.activation} - {1'b0, cfg.input_zero_point});
         wgt_s = $signed({1'b0, req_data.weight} - {1'b0, cfg.weight_zero_point});
      end
      pair_prod = act_s * wgt_s;
   end

   // Wrapping accumulator with a sticky signed overflow flag.
   always_comb begin
      addend  = cmd.bias_add ? bias_ff : 32'(pair_prod);
      acc_sum = acc_ff + addend;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      priority if (cmd.load_out) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.accum || cmd.bias_add) begin
         acc_in = acc_sum;
         if (((acc_ff[31] ^ acc_sum[31]) & (addend[31] ^ acc_sum[31])) == 1'b1) begin
            ovf_in = 1'b1;
         end
      end
   end

   // Scale multiply: signed accumulator by unsigned multiplier.
   assign mul_full = acc_ff * $signed({1'b0, cfg.scale_mult});

   // Rounding shift; right shifts round half up, left shifts saturate.
   always_comb begin
      rsh_amt  = cfg.scale_shift[5:0];
      half_idx = rsh_amt - 6'd1;
      rsh_val  = (prod_ff >>> rsh_amt) + $signed({63'd0, prod_ff[half_idx]});
      lsh_amt  = 7'(-cfg.scale_shift);
      prod_cl  = clamp64(prod_ff);
      lsh_wide = 72'(prod_cl) <<< lsh_amt[5:0];
      priority if (cfg.scale_shift == 7'sd0) begin
         shift_in = prod_cl;
      end else if (!cfg.scale_shift[6]) begin
         shift_in = clamp64(rsh_val);
      end else if (lsh_amt >= 7'd34) begin
         if (prod_cl == 38'sd0)  shift_in = '0;
         else if (prod_cl[37])   shift_in = CLAMP_LO;
         else                    shift_in = CLAMP_HI;
      end else begin
         shift_in = clamp72(lsh_wide);
      end
   end

   // Output zero point and saturation to out_bits.
   always_comb begin
      priority if (cfg.out_bits == 6'd0) sat_bits = 6'd1;
      else if (cfg.out_bits > 6'd32)     sat_bits = 6'd32;
      else                               sat_bits = cfg.out_bits;
      if (cfg.signed_mode) begin
         sat_val = 39'(shift_ff);
         sat_hi  = (39'sd1 <<< (sat_bits - 6'd1)) - 39'sd1;
         sat_lo  = -(39'sd1 <<< (sat_bits - 6'd1));
      end else begin
         sat_val = 39'(shift_ff) + $signed({31'd0, cfg.output_zero_point});
         sat_hi  = (39'sd1 <<< sat_bits) - 39'sd1;
         sat_lo  = '0;
      end
      priority if (sat_val > sat_hi) sat_res = sat_hi;
      else if (sat_val < sat_lo)     sat_res = sat_lo;
      else                           sat_res = sat_val;
   end

   // Row state.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   // Pipeline and response payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accum)    bias_ff  <= req_data.bias;
      if (cmd.multiply) prod_ff  <= mul_full[63:0];
      if (cmd.shift)    shift_ff <= shift_in;
      if (cmd.load_out) begin
         rsp_ff.out_value <= sat_res[32:0];
         rsp_ff.overflow  <= ovf_ff;
      end
   end

endmodule

// File: sv/quantized_dot_product_requant.sv
// ---------------------------------------------------------------------------
// quantized_dot_product_requant: int8 dot product row with requantization
// Streams activation/weight pairs into a MAC and emits one requantized,
// saturated result per row.
// ---------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) takes one pair per
//   cycle while a row accumulates. The pair marked last also carries the row
//   bias; after its transfer the request side stalls while the bias add,
//   scale multiply, rounding shift and saturation run, one stage per cycle
//   while the response register can take a result. The saturation stage
//   loads the result into the response channel (rsp_valid, rsp_stall,
//   rsp_data) and raises rsp_valid.
//   A waiting result sits in the response register while the next row
//   accumulates. If the receiver still stalls when the following row is
//   finished, the block holds that row in the saturation stage and stalls
//   requests until the register drains.
//   The configuration port (csr_valid, csr_ready, csr_index, csr_data) is
//   always ready; users write it only while the block is idle (unchecked).
//   Reset clears accumulator and overflow flag, loads the register defaults.
// ---------------------------------------------------------------------------
module quantized_dot_product_requant (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qdpr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qdpr_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   qdpr_pkg::cfg_type    cfg;
   qdpr_pkg::cmd_type    cmd;
   qdpr_pkg::status_type status;

   // Register file.
   qdpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Row sequencer.
   qdpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   qdpr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
